// ===== sv/tcsq_pkg.sv =====
// Package for the two-class service queue: depth, widths, request kinds,
// result status codes and the control structs shared by the queue modules.
// No dependencies.
package tcsq_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TICKET_W    = 16;
  localparam int PORT_W      = 4;

  localparam logic [1:0] KIND_ENQ_PRIORITY = 2'd0;
  localparam logic [1:0] KIND_ENQ_NORMAL   = 2'd1;
  localparam logic [1:0] KIND_SERVE        = 2'd2;

  localparam logic [2:0] ST_ENQUEUED = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_SERVED   = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;

  localparam logic CLASS_NORMAL   = 1'b0;
  localparam logic CLASS_PRIORITY = 1'b1;

  localparam logic [PORT_W-1:0] PORT_PRIORITY = 4'd1;
  localparam logic [PORT_W-1:0] PORT_LAST     = 4'd4;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ===== sv/tcsq_cell.sv =====
// One storage cell of a shifting ticket queue.
// Loads a new ticket or takes its neighbor's ticket on a pop. Depends on tcsq_pkg.
module tcsq_cell (
  input  logic                          clk,
  input  tcsq_pkg::cell_ctl_t           ctl,
  input  logic [tcsq_pkg::TICKET_W-1:0] din,
  input  logic [tcsq_pkg::TICKET_W-1:0] nbr,
  output logic [tcsq_pkg::TICKET_W-1:0] q
);
  import tcsq_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q <= nbr;
    end else if (ctl.load) begin
      q <= din;
    end
  end

endmodule

// ===== sv/tcsq_queue.sv =====
// Ticket FIFO built as a row of cells; the head is always cell 0.
// Tickets move one cell toward the head on each pop. Depends on tcsq_pkg, tcsq_cell.
module tcsq_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  tcsq_pkg::queue_ctl_t          ctl,
  input  logic [tcsq_pkg::TICKET_W-1:0] din,
  output logic [tcsq_pkg::TICKET_W-1:0] head,
  output tcsq_pkg::queue_stat_t         stat
);
  import tcsq_pkg::*;

  logic [CNT_W-1:0]    count;
  logic [TICKET_W-1:0] cell_q [QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t           cctl;
    logic [TICKET_W-1:0] nbr;

    assign cctl.shift = ctl.pop;
    assign cctl.load  = ctl.push && (count == CNT_W'(i));

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nbr = cell_q[i];
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    tcsq_cell u_cell (
      .clk (clk),
      .ctl (cctl),
      .din (din),
      .nbr (nbr),
      .q   (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.push && !ctl.pop) begin
      count <= count + CNT_W'(1);
    end else if (ctl.pop && !ctl.push) begin
      count <= count - CNT_W'(1);
    end
  end

  assign head       = cell_q[0];
  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

// ===== sv/two_class_service_queue.sv =====
// Two-class service queue: strict-priority scheduler over two ticket FIFOs.
// Top level; depends on tcsq_pkg and tcsq_queue.
//
// Each input transfer is an enqueue (priority or normal) or a serve request
// from port 1..4; every transfer gives exactly one registered result
// transfer. Port 1 serves the priority queue first, ports 2..4 only the normal
// queue. One item per cycle: each queue is a row of QUEUE_DEPTH cells that
// shifts once per pop, so push, pop and status all update together; the
// result register admits a new item whenever it is empty or being drained.
module two_class_service_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // ticket[15:0], port[19:16], zero[23:20]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // served_ticket[15:0], served_port[19:16],
                                 // served_class[20], zero[23:21]
  output logic [2:0]  m_tuser    // status[2:0]
);
  import tcsq_pkg::*;

  logic                accept;
  logic [1:0]          kind;
  logic [TICKET_W-1:0] ticket;
  logic [PORT_W-1:0]   port;
  logic                port_ok;

  queue_ctl_t          pri_ctl, nrm_ctl;
  queue_stat_t         pri_stat, nrm_stat;
  logic [TICKET_W-1:0] pri_head, nrm_head;

  logic [2:0]          status_next;
  logic [TICKET_W-1:0] ticket_next;
  logic                class_next;

  logic [2:0]          status;
  logic [TICKET_W-1:0] served_ticket;
  logic [PORT_W-1:0]   served_port;
  logic                served_class;

  assign kind    = s_tuser;
  assign ticket  = s_tdata[TICKET_W-1:0];
  assign port    = s_tdata[TICKET_W +: PORT_W];
  assign port_ok = (port >= PORT_PRIORITY) && (port <= PORT_LAST);

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    pri_ctl     = '0;
    nrm_ctl     = '0;
    status_next = ST_UNKNOWN;
    ticket_next = '0;
    class_next  = CLASS_NORMAL;
    case (kind)
      KIND_ENQ_PRIORITY: begin
        class_next = CLASS_PRIORITY;
        if (pri_stat.full) begin
          status_next = ST_FULL;
        end else begin
          status_next  = ST_ENQUEUED;
          pri_ctl.push = accept;
        end
      end
      KIND_ENQ_NORMAL: begin
        if (nrm_stat.full) begin
          status_next = ST_FULL;
        end else begin
          status_next  = ST_ENQUEUED;
          nrm_ctl.push = accept;
        end
      end
      KIND_SERVE: begin
        if (port_ok) begin
          if (port == PORT_PRIORITY && !pri_stat.empty) begin
            status_next = ST_SERVED;
            ticket_next = pri_head;
            class_next  = CLASS_PRIORITY;
            pri_ctl.pop = accept;
          end else if (!nrm_stat.empty) begin
            status_next = ST_SERVED;
            ticket_next = nrm_head;
            nrm_ctl.pop = accept;
          end else begin
            status_next = ST_EMPTY;
          end
        end
      end
      default: begin
        status_next = ST_UNKNOWN;
      end
    endcase
  end

  tcsq_queue u_pri (
    .clk  (clk),
    .rst  (rst),
    .ctl  (pri_ctl),
    .din  (ticket),
    .head (pri_head),
    .stat (pri_stat)
  );

  tcsq_queue u_nrm (
    .clk  (clk),
    .rst  (rst),
    .ctl  (nrm_ctl),
    .din  (ticket),
    .head (nrm_head),
    .stat (nrm_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      served_ticket <= ticket_next;
      served_port   <= port;
      served_class  <= class_next;
    end
  end

  assign m_tuser = status;
  assign m_tdata = {3'b000, served_class, served_port, served_ticket};

endmodule

// ===== verif/service_queue_checker.sv =====
// Result checker for two_class_service_queue: watches both streams, keeps its
// own copy of the priority and normal ticket rings and checks every result
// transfer field by field. Depends on tcsq_pkg.
module service_queue_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // ticket[15:0], port[19:16], zero[23:20]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // served_ticket[15:0], served_port[19:16],
                                 // served_class[20], zero[23:21]
  input  logic [2:0]  m_tuser,   // status[2:0]
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import tcsq_pkg::*;

  typedef struct packed {
    logic [2:0]          status;
    logic [TICKET_W-1:0] ticket;
    logic [PORT_W-1:0]   port;
    logic                cls;
  } service_result_t;

  // index 0 is the normal ring, index 1 the priority ring
  logic [TICKET_W-1:0] ring_slots [2][QUEUE_DEPTH];
  int                  ring_head [2];
  int                  ring_held [2];
  service_result_t     awaited_results [$];

  function automatic service_result_t predict_service(logic [1:0] kind,
                                                      logic [TICKET_W-1:0] ticket,
                                                      logic [PORT_W-1:0] port);
    service_result_t r;
    logic            cls;
    r.status = ST_UNKNOWN;
    r.ticket = '0;
    r.port   = port;
    r.cls    = CLASS_NORMAL;
    case (kind)
      KIND_ENQ_PRIORITY, KIND_ENQ_NORMAL: begin
        cls   = (kind == KIND_ENQ_PRIORITY) ? CLASS_PRIORITY : CLASS_NORMAL;
        r.cls = cls;
        if (ring_held[cls] < QUEUE_DEPTH) begin
          ring_slots[cls][(ring_head[cls] + ring_held[cls]) % QUEUE_DEPTH] = ticket;
          ring_held[cls]++;
          r.status = ST_ENQUEUED;
        end else begin
          r.status = ST_FULL;
        end
      end
      KIND_SERVE: begin
        if (port >= PORT_PRIORITY && port <= PORT_LAST) begin
          r.status = ST_EMPTY;
          if (port == PORT_PRIORITY && ring_held[CLASS_PRIORITY] > 0) begin
            cls = CLASS_PRIORITY;
          end else begin
            cls = CLASS_NORMAL;
          end
          if (ring_held[cls] > 0) begin
            r.status       = ST_SERVED;
            r.cls          = cls;
            r.ticket       = ring_slots[cls][ring_head[cls]];
            ring_head[cls] = (ring_head[cls] + 1) % QUEUE_DEPTH;
            ring_held[cls]--;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    if (mismatches < 40) begin
      $display("mismatch in %s: got 0x%0h, expected 0x%0h", field, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    service_result_t want;
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        ring_head[c] = 0;
        ring_held[c] = 0;
      end
      awaited_results.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(predict_service(s_tuser, s_tdata[TICKET_W-1:0],
                                                  s_tdata[TICKET_W +: PORT_W]));
      end
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with nothing pending", int'(m_tdata), 0);
        end else begin
          want = awaited_results.pop_front();
          if (m_tuser != want.status) begin
            flag_mismatch("status", int'(m_tuser), int'(want.status));
          end
          if (m_tdata[TICKET_W-1:0] != want.ticket) begin
            flag_mismatch("served_ticket", int'(m_tdata[TICKET_W-1:0]), int'(want.ticket));
          end
          if (m_tdata[TICKET_W +: PORT_W] != want.port) begin
            flag_mismatch("served_port", int'(m_tdata[TICKET_W +: PORT_W]),
                          int'(want.port));
          end
          if (m_tdata[TICKET_W+PORT_W] != want.cls) begin
            flag_mismatch("served_class", int'(m_tdata[TICKET_W+PORT_W]), int'(want.cls));
          end
          if (m_tdata[23:TICKET_W+PORT_W+1] != '0) begin
            flag_mismatch("tdata padding", int'(m_tdata[23:TICKET_W+PORT_W+1]), 0);
          end
        end
      end
    end
    outstanding <= awaited_results.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for two_class_service_queue: clock, reset, directed and
// random request traffic with random backpressure, and the final verdict.
// Depends on tcsq_pkg, two_class_service_queue and service_queue_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcsq_pkg::*;

  localparam logic [1:0] KIND_UNDEFINED = 2'd3;
  localparam int RANDOM_ITEMS = 850;
  localparam int CALM_ITEMS   = 150;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // ticket[15:0], port[19:16], zero[23:20]
  logic [1:0]  s_tuser  = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;         // served_ticket[15:0], served_port[19:16],
                                // served_class[20], zero[23:21]
  logic [2:0]  m_tuser;         // status[2:0]
  int          mismatches;
  int          outstanding;
  bit          calm = 1'b0;

  two_class_service_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  service_queue_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

  // result side backpressure
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall == 0 && !calm && $urandom_range(0, 11) == 0) stall = $urandom_range(1, 15);
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [TICKET_W-1:0] ticket,
                           logic [PORT_W-1:0] port);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {4'b0, port, ticket};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  function automatic logic [TICKET_W-1:0] corner_ticket(int n);
    case (n)
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'hAAAA;
      3: return 16'h5555;
      default: return TICKET_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // mood 0 leans to enqueues, 1 to serves, 2 is balanced
  task automatic send_random_item(int mood);
    int                roll;
    int                enq_share;
    logic [1:0]        kind;
    logic [PORT_W-1:0] port;
    roll      = $urandom_range(0, 99);
    enq_share = (mood == 0) ? 62 : (mood == 1) ? 28 : 46;
    if (roll < 3) begin
      kind = KIND_UNDEFINED;
    end else if (roll < 3 + enq_share) begin
      kind = $urandom_range(0, 1) ? KIND_ENQ_PRIORITY : KIND_ENQ_NORMAL;
    end else begin
      kind = KIND_SERVE;
    end
    if (kind != KIND_SERVE || $urandom_range(0, 15) == 0) begin
      port = PORT_W'($urandom_range(0, 15));
    end else if ($urandom_range(0, 1)) begin
      port = PORT_PRIORITY;
    end else begin
      port = PORT_W'($urandom_range(2, 4));
    end
    send_item(kind, TICKET_W'($urandom_range(0, 65535)), port);
  endtask

  initial begin
    int mood;
    mood = 2;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty queues, bad ports, undefined kind
    send_item(KIND_SERVE, 16'h1234, PORT_PRIORITY);
    send_item(KIND_SERVE, 16'hFFFF, 4'd2);
    send_item(KIND_SERVE, 16'h0000, 4'd0);
    send_item(KIND_SERVE, 16'hFFFF, 4'd15);
    send_item(KIND_UNDEFINED, 16'hFFFF, 4'd15);
    // fill both rings past full
    for (int n = 0; n <= QUEUE_DEPTH; n++) begin
      send_item(KIND_ENQ_PRIORITY, corner_ticket(n), 4'(n));
    end
    for (int n = 0; n <= QUEUE_DEPTH; n++) begin
      send_item(KIND_ENQ_NORMAL, corner_ticket(n), 4'(15 - n));
    end
    send_item(KIND_SERVE, 16'h0000, PORT_PRIORITY);
    send_item(KIND_SERVE, 16'h0000, 4'd2);
    send_item(KIND_SERVE, 16'h0000, 4'd3);
    send_item(KIND_SERVE, 16'h0000, PORT_LAST);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) mood = $urandom_range(0, 2);
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      send_random_item(mood);
    end
    s_tvalid <= 1'b0;

    for (int c = 0; c < 2000 && outstanding != 0; c++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
